// ----- src/eil_pkg.sv -----
// shared types, command codes and default sizes for the event interval logger
// no dependencies
package eil_pkg;

    localparam int CHANNELS_DEF  = 4;
    localparam int LOG_DEPTH_DEF = 8;
    localparam int TYPES         = 4;

    localparam logic [1:0] CMD_UPDATE = 2'd0;
    localparam logic [1:0] CMD_READ   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  swell_flags;
        logic [3:0]  sag_flags;
        logic [3:0]  creep_flags;
        logic [3:0]  active_flags;
        logic [31:0] timestamp;
        logic [3:0]  slot_id;
        logic [2:0]  entry_offset;
    } item_t;

    typedef struct packed {
        logic        ok;
        logic        store_request;
        logic [7:0]  event_count;
        logic        slot_active;
        logic [31:0] start_time;
        logic [31:0] end_time;
    } result_t;

    typedef struct packed {
        logic visit;
        logic rd;
        logic clr;
    } lane_ctl_t;

    typedef struct packed {
        logic [7:0]  event_count;
        logic        slot_active;
        logic [31:0] start_time;
        logic [31:0] end_time;
    } lane_rd_t;

endpackage

// ----- src/eil_lane.sv -----
// one event type lane: per-channel slot state and the start/end log rings
// depends on eil_pkg
module eil_lane #(
    parameter int CHANNELS  = eil_pkg::CHANNELS_DEF,
    parameter int LOG_DEPTH = eil_pkg::LOG_DEPTH_DEF,
    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
    input  logic               clk,
    input  logic               rst_n,
    input  eil_pkg::lane_ctl_t ctl,
    input  logic [CW-1:0]      ch,
    input  logic [3:0]         flags,
    input  logic [31:0]        timestamp,
    input  logic [2:0]         entry_offset,
    output logic               closed,
    output eil_pkg::lane_rd_t  rd
);

    localparam int IW    = $clog2(LOG_DEPTH);
    localparam int FW    = (CHANNELS > 4) ? CHANNELS : 4;
    localparam int AW    = CW + IW;
    localparam int DEPTH = 2 ** AW;

    logic          open_reg  [CHANNELS];
    logic          wrap_reg  [CHANNELS];
    logic [IW-1:0] ring_reg  [CHANNELS];
    logic [7:0]    count_reg [CHANNELS];

    logic [31:0] start_mem [DEPTH];
    logic [31:0] end_mem   [DEPTH];

    logic [31:0]   start_q;
    logic [31:0]   end_q;
    logic          full_q;
    logic          atcur_q;
    logic          open_q;
    logic [7:0]    count_q;

    logic [IW-1:0] cur;
    logic [IW-1:0] cur_inc;
    logic          is_open;
    logic [FW-1:0] flags_sh;
    logic          present;
    logic          open_evt;
    logic          close_evt;
    logic [IW-1:0] off_n;
    logic [IW:0]   diff;
    logic [IW-1:0] idx;
    logic          full;
    logic          at_cur;

    always_comb
    begin
        cur       = ring_reg[ch];
        is_open   = open_reg[ch];
        cur_inc   = (cur == IW'(LOG_DEPTH - 1)) ? '0 : cur + IW'(1);
        flags_sh  = FW'(flags) >> ch;
        present   = flags_sh[0];
        open_evt  = ctl.visit && !is_open && present;
        close_evt = ctl.visit && is_open && !present;
        off_n     = IW'(entry_offset);
        diff      = {1'b0, cur} - {1'b0, off_n};
        idx       = diff[IW] ? IW'(diff + (IW + 1)'(LOG_DEPTH)) : diff[IW-1:0];
        at_cur    = (idx == cur);
        full      = !at_cur && (wrap_reg[ch] || (idx < cur));
    end

    assign closed = close_evt;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                open_reg[i]  <= 1'b0;
                wrap_reg[i]  <= 1'b0;
                ring_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else if (ctl.clr)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                open_reg[i]  <= 1'b0;
                wrap_reg[i]  <= 1'b0;
                ring_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else if (open_evt)
        begin
            open_reg[ch] <= 1'b1;
        end
        else if (close_evt)
        begin
            open_reg[ch]  <= 1'b0;
            ring_reg[ch]  <= cur_inc;
            count_reg[ch] <= count_reg[ch] + 8'd1;
            wrap_reg[ch]  <= wrap_reg[ch] || (cur == IW'(LOG_DEPTH - 1));
        end
    end

    // log rings, written on open and close, read one entry per read transfer
    always_ff @(posedge clk)
    begin
        if (open_evt)
        begin
            start_mem[{ch, cur}] <= timestamp;
        end
        if (close_evt)
        begin
            end_mem[{ch, cur}] <= timestamp;
        end
        if (ctl.rd)
        begin
            start_q <= start_mem[{ch, idx}];
            end_q   <= end_mem[{ch, idx}];
            full_q  <= full;
            atcur_q <= at_cur;
            open_q  <= is_open;
            count_q <= count_reg[ch];
        end
    end

    // the current entry only holds a start while the slot is open
    always_comb
    begin
        rd.event_count = count_q;
        rd.slot_active = open_q;
        rd.start_time  = (full_q || (atcur_q && open_q)) ? start_q : '0;
        rd.end_time    = full_q ? end_q : '0;
    end

endmodule

// ----- src/eil_merge.sv -----
// merging stage: combines the close flags of all lanes and picks the read lane
// depends on eil_pkg
module eil_merge (
    input  eil_pkg::lane_rd_t lane_rd [eil_pkg::TYPES],
    input  logic [eil_pkg::TYPES-1:0] lane_closed,
    input  logic [1:0]        sel,
    output logic              closed_any,
    output eil_pkg::lane_rd_t rd
);

    always_comb
    begin
        closed_any = |lane_closed;
        unique case (sel)
            2'd0:    rd = lane_rd[0];
            2'd1:    rd = lane_rd[1];
            2'd2:    rd = lane_rd[2];
            default: rd = lane_rd[3];
        endcase
    end

endmodule

// ----- src/event_interval_logger.sv -----
// top level of the event interval logger: command sequencer, four type lanes, merge
// depends on eil_pkg, eil_lane, eil_merge
//
// A command is taken when start is high and busy is low; its result is shown
// for one cycle with done high and cannot be stalled. During an update the
// four type lanes work side by side, each visiting its CHANNELS slots one per
// cycle, all lanes stepping the same channel index. A read goes through slot
// decode, a registered log memory read and the result; a clear, an unknown
// command or a rejected read is answered straight from idle. Clear resets the
// slot state directly; no memory sweep is needed.
module event_interval_logger #(
    parameter int CHANNELS  = eil_pkg::CHANNELS_DEF,
    parameter int LOG_DEPTH = eil_pkg::LOG_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  eil_pkg::item_t   item,
    output logic             done,
    output eil_pkg::result_t result
);

    localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam logic [7:0] C1 = 8'(CHANNELS);
    localparam logic [7:0] C2 = 8'(2 * CHANNELS);
    localparam logic [7:0] C3 = 8'(3 * CHANNELS);
    localparam logic [7:0] C4 = 8'(4 * CHANNELS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_UPD  = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_RDW  = 2'd3;

    logic [1:0]       state_reg,  state_next;
    logic [CW-1:0]    cnt_reg,    cnt_next;
    logic             req_reg,    req_next;
    logic             done_reg,   done_next;
    eil_pkg::result_t result_reg, result_next;
    eil_pkg::item_t   item_reg,   item_next;

    logic              accept;
    logic              bad_read;
    logic              last;
    logic [7:0]        sid8;
    logic [1:0]        rd_type;
    logic [7:0]        rd_ch8;
    logic [CW-1:0]     lane_ch;
    logic [3:0]        lane_flags [eil_pkg::TYPES];
    logic [eil_pkg::TYPES-1:0] lane_closed;
    eil_pkg::lane_rd_t lane_rd [eil_pkg::TYPES];
    eil_pkg::lane_ctl_t ctl;
    logic              closed_any;
    eil_pkg::lane_rd_t rd_sel;

    assign busy   = (state_reg != S_IDLE);
    assign accept = start && !busy;
    assign done   = done_reg;
    assign result = result_reg;

    assign bad_read = (8'(item.slot_id) >= C4) || (8'(item.entry_offset) >= 8'(LOG_DEPTH));
    assign last     = (cnt_reg == CW'(CHANNELS - 1));

    // slot id to type and channel
    always_comb
    begin
        sid8 = 8'(item_reg.slot_id);
        priority if (sid8 >= C3)
        begin
            rd_type = 2'd3;
            rd_ch8  = sid8 - C3;
        end
        else if (sid8 >= C2)
        begin
            rd_type = 2'd2;
            rd_ch8  = sid8 - C2;
        end
        else if (sid8 >= C1)
        begin
            rd_type = 2'd1;
            rd_ch8  = sid8 - C1;
        end
        else
        begin
            rd_type = 2'd0;
            rd_ch8  = sid8;
        end
    end

    always_comb
    begin
        lane_ch       = (state_reg == S_UPD) ? cnt_reg : CW'(rd_ch8);
        lane_flags[0] = item_reg.swell_flags;
        lane_flags[1] = item_reg.sag_flags;
        lane_flags[2] = item_reg.creep_flags;
        lane_flags[3] = item_reg.active_flags;
        ctl.visit     = (state_reg == S_UPD);
        ctl.rd        = (state_reg == S_RD);
        ctl.clr       = accept && (item.cmd == eil_pkg::CMD_CLEAR);
    end

    for (genvar t = 0; t < eil_pkg::TYPES; t++)
    begin : g_lane
        eil_lane #(
            .CHANNELS  (CHANNELS),
            .LOG_DEPTH (LOG_DEPTH)
        ) u_lane (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctl          (ctl),
            .ch           (lane_ch),
            .flags        (lane_flags[t]),
            .timestamp    (item_reg.timestamp),
            .entry_offset (item_reg.entry_offset),
            .closed       (lane_closed[t]),
            .rd           (lane_rd[t])
        );
    end

    eil_merge u_merge (
        .lane_rd     (lane_rd),
        .lane_closed (lane_closed),
        .sel         (rd_type),
        .closed_any  (closed_any),
        .rd          (rd_sel)
    );

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        req_next    = req_reg;
        done_next   = 1'b0;
        result_next = result_reg;
        item_next   = item_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    item_next   = item;
                    result_next = '0;
                    unique case (item.cmd)
                        eil_pkg::CMD_UPDATE:
                        begin
                            state_next = S_UPD;
                            cnt_next   = '0;
                            req_next   = 1'b0;
                        end
                        eil_pkg::CMD_READ:
                        begin
                            if (bad_read)
                            begin
                                done_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_RD;
                            end
                        end
                        eil_pkg::CMD_CLEAR:
                        begin
                            done_next      = 1'b1;
                            result_next.ok = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end
            S_UPD:
            begin
                req_next = req_reg || closed_any;
                cnt_next = cnt_reg + CW'(1);
                if (last)
                begin
                    state_next                = S_IDLE;
                    done_next                 = 1'b1;
                    result_next               = '0;
                    result_next.ok            = 1'b1;
                    result_next.store_request = req_reg || closed_any;
                end
            end
            S_RD:
            begin
                state_next = S_RDW;
            end
            default:
            begin
                state_next                = S_IDLE;
                done_next                 = 1'b1;
                result_next               = '0;
                result_next.ok            = 1'b1;
                result_next.event_count   = rd_sel.event_count;
                result_next.slot_active   = rd_sel.slot_active;
                result_next.start_time    = rd_sel.start_time;
                result_next.end_time      = rd_sel.end_time;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            req_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            req_reg   <= req_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
        item_reg   <= item_next;
    end

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RDW |=> done && result.ok)
        else $error("read wait not followed by result");

    a_ctl_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.visit, ctl.rd, ctl.clr}))
        else $error("lane controls overlap");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.ok |-> !result.store_request && result.event_count == 8'd0
            && !result.slot_active)
        else $error("rejected command carries data");

    a_update_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_UPD && last |=> done && result.ok && !busy)
        else $error("update did not finish after last channel");

endmodule

// ----- verif/tb.sv -----
// self-checking testbench for event_interval_logger: directed and random commands,
// each result checked against a scoreboard that keeps its own slot and log state
// depends on eil_pkg and event_interval_logger
module tb;
    import eil_pkg::*;

    localparam int N_SLOTS     = TYPES * CHANNELS_DEF;
    localparam int DEPTH       = LOG_DEPTH_DEF;
    localparam int RAND_ITEMS  = 700;
    localparam int QUIET_LIMIT = 2000;
    localparam int TAIL_CYCLES = CHANNELS_DEF + 8;

    localparam logic [1:0] CMD_UNUSED = 2'd3;

    class interval_scoreboard;
        bit          slot_open [N_SLOTS];
        int          ring_pos  [N_SLOTS];
        bit [7:0]    done_cnt  [N_SLOTS];
        bit [31:0]   start_log [N_SLOTS][DEPTH];
        bit [31:0]   end_log   [N_SLOTS][DEPTH];
        result_t     pending[$];
        int          errors;
        int          checked;
        int          n_update;
        int          n_closing;
        int          n_read;
        int          n_clear;
        int          n_unknown;

        function void wipe_logs();
            for (int s = 0; s < N_SLOTS; s++)
            begin
                slot_open[s] = 1'b0;
                ring_pos[s]  = 0;
                done_cnt[s]  = '0;
                for (int e = 0; e < DEPTH; e++)
                begin
                    start_log[s][e] = '0;
                    end_log[s][e]   = '0;
                end
            end
        endfunction

        // apply one accepted command and queue the result it must produce
        function void note_item(item_t it);
            result_t    r;
            logic [3:0] masks [TYPES];
            int         s;
            int         cur;
            int         idx;
            bit         present;
            r = '0;
            masks[0] = it.swell_flags;
            masks[1] = it.sag_flags;
            masks[2] = it.creep_flags;
            masks[3] = it.active_flags;
            case (it.cmd)
                CMD_UPDATE:
                begin
                    n_update++;
                    r.ok = 1'b1;
                    for (int t = 0; t < TYPES; t++)
                    begin
                        for (int ch = 0; ch < CHANNELS_DEF; ch++)
                        begin
                            s       = t * CHANNELS_DEF + ch;
                            cur     = ring_pos[s];
                            present = (ch < 4) ? masks[t][ch] : 1'b0;
                            if (!slot_open[s])
                            begin
                                if (present)
                                begin
                                    start_log[s][cur] = it.timestamp;
                                    end_log[s][cur]   = '0;
                                    slot_open[s]      = 1'b1;
                                end
                            end
                            else if (!present)
                            begin
                                end_log[s][cur]   = it.timestamp;
                                cur               = (cur + 1) % DEPTH;
                                ring_pos[s]       = cur;
                                start_log[s][cur] = '0;
                                end_log[s][cur]   = '0;
                                done_cnt[s]       = done_cnt[s] + 8'd1;
                                slot_open[s]      = 1'b0;
                                r.store_request   = 1'b1;
                            end
                        end
                    end
                    if (r.store_request)
                        n_closing++;
                end
                CMD_READ:
                begin
                    n_read++;
                    if (int'(it.slot_id) < N_SLOTS && int'(it.entry_offset) < DEPTH)
                    begin
                        s   = int'(it.slot_id);
                        idx = (ring_pos[s] + DEPTH - int'(it.entry_offset)) % DEPTH;
                        r.ok          = 1'b1;
                        r.event_count = done_cnt[s];
                        r.slot_active = slot_open[s];
                        r.start_time  = start_log[s][idx];
                        r.end_time    = end_log[s][idx];
                    end
                end
                CMD_CLEAR:
                begin
                    n_clear++;
                    wipe_logs();
                    r.ok = 1'b1;
                end
                default:
                    n_unknown++;
            endcase
            pending.push_back(r);
        endfunction

        task report(string msg);
            $display("MISMATCH: %s", msg);
            errors++;
        endtask

        task check_result(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                report($sformatf("unexpected result %h", got));
            end
            else
            begin
                want = pending.pop_front();
                checked++;
                if (got.ok !== want.ok)
                    report($sformatf("#%0d ok %b want %b", checked, got.ok, want.ok));
                if (got.store_request !== want.store_request)
                    report($sformatf("#%0d store_request %b want %b", checked,
                                     got.store_request, want.store_request));
                if (got.event_count !== want.event_count)
                    report($sformatf("#%0d event_count %h want %h", checked,
                                     got.event_count, want.event_count));
                if (got.slot_active !== want.slot_active)
                    report($sformatf("#%0d slot_active %b want %b", checked,
                                     got.slot_active, want.slot_active));
                if (got.start_time !== want.start_time)
                    report($sformatf("#%0d start_time %h want %h", checked,
                                     got.start_time, want.start_time));
                if (got.end_time !== want.end_time)
                    report($sformatf("#%0d end_time %h want %h", checked,
                                     got.end_time, want.end_time));
            end
        endtask
    endclass

    logic    clk   = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    item_t   item  = '0;
    logic    busy;
    logic    done;
    result_t result;

    interval_scoreboard sb;
    int                 idle_pct;
    int                 quiet_cycles;
    logic [3:0]         last_masks [TYPES];
    logic [31:0]        ts_now;

    event_interval_logger u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // results cannot be stalled, so every strobe is a transfer
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(result);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic item_t make_item(logic [1:0] cmd, logic [3:0] sw, logic [3:0] sg,
                                        logic [3:0] cr, logic [3:0] ac, logic [31:0] ts,
                                        logic [3:0] sid, logic [2:0] off);
        item_t it;
        it.cmd          = cmd;
        it.swell_flags  = sw;
        it.sag_flags    = sg;
        it.creep_flags  = cr;
        it.active_flags = ac;
        it.timestamp    = ts;
        it.slot_id      = sid;
        it.entry_offset = off;
        return it;
    endfunction

    task send(item_t it);
        while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_item(it);
    endtask

    function automatic logic [31:0] next_timestamp();
        case ($urandom_range(0, 9))
            0:       ts_now = 32'h0;
            1:       ts_now = 32'hFFFF_FFFF;
            2, 3:    ts_now = $urandom;
            default: ts_now = ts_now + $urandom_range(1, 1 << 20);
        endcase
        return ts_now;
    endfunction

    function automatic item_t random_item();
        item_t it;
        int    pick;
        it   = make_item(CMD_READ, 4'($urandom), 4'($urandom), 4'($urandom), 4'($urandom),
                         $urandom, 4'($urandom), 3'($urandom));
        pick = $urandom_range(0, 199);
        if (pick == 0)
        begin
            it.cmd = CMD_CLEAR;
        end
        else if (pick < 5)
        begin
            it.cmd = CMD_UNUSED;
        end
        else if (pick < 140)
        begin
            it.cmd = CMD_UPDATE;
            for (int t = 0; t < TYPES; t++)
            begin
                // toggle the previous conditions half of the time so events open and close often
                if ($urandom_range(0, 1))
                    last_masks[t] = ~last_masks[t];
                else
                    last_masks[t] = 4'($urandom);
            end
            it.swell_flags  = last_masks[0];
            it.sag_flags    = last_masks[1];
            it.creep_flags  = last_masks[2];
            it.active_flags = last_masks[3];
            it.timestamp    = next_timestamp();
        end
        return it;
    endfunction

    initial
    begin
        sb = new();
        sb.wipe_logs();
        idle_pct     = 0;
        quiet_cycles = 0;
        ts_now       = '0;
        for (int t = 0; t < TYPES; t++)
            last_masks[t] = '0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty logs, unknown command, open, hold, close, wrap of offsets, clear
        send(make_item(CMD_READ, 4'h0, 4'h0, 4'h0, 4'h0, 32'h0, 4'd0, 3'd0));
        send(make_item(CMD_UNUSED, 4'hF, 4'hF, 4'hF, 4'hF, 32'hFFFF_FFFF, 4'd15, 3'd7));
        send(make_item(CMD_UPDATE, 4'hF, 4'hF, 4'hF, 4'hF, 32'hFFFF_FFFF, 4'd0, 3'd0));
        send(make_item(CMD_READ, 4'h0, 4'h0, 4'h0, 4'h0, 32'h0, 4'd15, 3'd0));
        send(make_item(CMD_UPDATE, 4'hF, 4'hF, 4'hF, 4'hF, 32'd123, 4'd0, 3'd0));
        send(make_item(CMD_UPDATE, 4'h0, 4'h0, 4'h0, 4'h0, 32'h0, 4'd0, 3'd0));
        send(make_item(CMD_READ, 4'h0, 4'h0, 4'h0, 4'h0, 32'h0, 4'd5, 3'd1));
        send(make_item(CMD_READ, 4'h0, 4'h0, 4'h0, 4'h0, 32'h0, 4'd5, 3'd0));
        send(make_item(CMD_UPDATE, 4'hA, 4'h5, 4'hC, 4'h3, 32'h5555_AAAA, 4'd0, 3'd0));
        send(make_item(CMD_READ, 4'h0, 4'h0, 4'h0, 4'h0, 32'h0, 4'd1, 3'd0));
        send(make_item(CMD_UPDATE, 4'h0, 4'h0, 4'h0, 4'h0, 32'hAAAA_5555, 4'd0, 3'd0));
        send(make_item(CMD_READ, 4'h0, 4'h0, 4'h0, 4'h0, 32'h0, 4'd1, 3'd1));
        send(make_item(CMD_READ, 4'h0, 4'h0, 4'h0, 4'h0, 32'h0, 4'd1, 3'd7));
        send(make_item(CMD_READ, 4'h0, 4'h0, 4'h0, 4'h0, 32'h0, 4'd0, 3'd7));
        send(make_item(CMD_UPDATE, 4'h0, 4'h0, 4'h0, 4'h0, 32'd1, 4'd0, 3'd0));
        send(make_item(CMD_UPDATE, 4'h8, 4'h0, 4'h0, 4'h1, 32'd77, 4'd0, 3'd0));
        send(make_item(CMD_CLEAR, 4'h0, 4'h0, 4'h0, 4'h0, 32'h0, 4'd0, 3'd0));
        send(make_item(CMD_READ, 4'h0, 4'h0, 4'h0, 4'h0, 32'h0, 4'd3, 3'd0));
        send(make_item(CMD_READ, 4'h0, 4'h0, 4'h0, 4'h0, 32'h0, 4'd5, 3'd1));
        send(make_item(CMD_READ, 4'h0, 4'h0, 4'h0, 4'h0, 32'h0, 4'd15, 3'd7));

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            case (n / (RAND_ITEMS / 4))
                0:       idle_pct = 0;
                1:       idle_pct = 52;
                2:       idle_pct = 30;
                default: idle_pct = 0;
            endcase
            send(random_item());
        end
        start <= 1'b0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d commands: %0d updates (%0d closing events), %0d reads,",
                 sb.checked, sb.n_update, sb.n_closing, sb.n_read);
        $display("%0d clears and %0d unknown commands, with and without sender gaps",
                 sb.n_clear, sb.n_unknown);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/eil_pkg.sv
src/eil_lane.sv
src/eil_merge.sv
src/event_interval_logger.sv
verif/tb.sv
